// ===== rtl/tceu_pkg.sv =====
// Shared types and constants for the tiny CPU execute unit.
`timescale 1ns / 1ps
`default_nettype none

package tceu_pkg;

  // Field widths
  localparam int INSTR_W   = 32;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int REG_IDX_W = 4;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Decoupling queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_END = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_END = 1'b1;
  localparam logic [ADDR_W-1:0]    ROM_END_RST = 16'h0000;
  localparam logic [ADDR_W-1:0]    RAM_END_RST = 16'h0400;

  // Opcodes
  localparam logic [7:0] OPC_MVR   = 8'h00;
  localparam logic [7:0] OPC_MVI   = 8'h01;
  localparam logic [7:0] OPC_ADDR  = 8'h02;
  localparam logic [7:0] OPC_ADDI  = 8'h03;
  localparam logic [7:0] OPC_SUBR  = 8'h04;
  localparam logic [7:0] OPC_SUBI  = 8'h05;
  localparam logic [7:0] OPC_CMP   = 8'h06;
  localparam logic [7:0] OPC_JMP   = 8'h07;
  localparam logic [7:0] OPC_JZ    = 8'h08;
  localparam logic [7:0] OPC_JNZ   = 8'h09;
  localparam logic [7:0] OPC_HLT   = 8'h0A;
  localparam logic [7:0] OPC_NOP   = 8'h0B;
  localparam logic [7:0] OPC_LOAD  = 8'h0C;
  localparam logic [7:0] OPC_STORE = 8'h0D;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ROM   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  // Instruction class after decode
  typedef enum logic [3:0] {
    CL_MVR, CL_MVI, CL_ADDR, CL_ADDI, CL_SUBR, CL_SUBI, CL_CMP, CL_JMP,
    CL_JZ, CL_JNZ, CL_HLT, CL_NOP, CL_LOAD, CL_STORE, CL_BAD
  } cls_t;

  // Decoded word handed from front to back
  typedef struct packed {
    cls_t                 cls;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [ADDR_W-1:0]    imm;
    logic [DATA_W-1:0]    ld;
    logic [ERR_W-1:0]     err;
  } dec_t;

  // Result word
  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] fetch_address;
    logic              zero_flag;
    logic              halted;
    logic              reg_write;
    logic [1:0]        written_register;
    logic [DATA_W-1:0] written_value;
    logic              store_valid;
    logic [ADDR_W-1:0] store_address;
    logic [DATA_W-1:0] store_data;
    logic [ERR_W-1:0]  error_code;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tceu_if.sv =====
// Valid/ready channel interfaces for instruction words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface tceu_in_if;
  import tceu_pkg::*;
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instruction;
  logic [INSTR_W-1:0] load_word;

  modport source (output valid, output instruction, output load_word, input ready);
  modport sink   (input valid, input instruction, input load_word, output ready);
endinterface

interface tceu_out_if;
  import tceu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_pc;
  logic [ADDR_W-1:0] fetch_address;
  logic              zero_flag;
  logic              halted;
  logic              reg_write;
  logic [1:0]        written_register;
  logic [DATA_W-1:0] written_value;
  logic              store_valid;
  logic [ADDR_W-1:0] store_address;
  logic [DATA_W-1:0] store_data;
  logic [ERR_W-1:0]  error_code;

  modport source (
    output valid, output next_pc, output fetch_address, output zero_flag,
    output halted, output reg_write, output written_register,
    output written_value, output store_valid, output store_address,
    output store_data, output error_code, input ready
  );
  modport sink (
    input valid, input next_pc, input fetch_address, input zero_flag,
    input halted, input reg_write, input written_register,
    input written_value, input store_valid, input store_address,
    input store_data, input error_code, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tceu_front.sv =====
// Front end: opcode classification, register field reduction, access range checks.
`timescale 1ns / 1ps
`default_nettype none

module tceu_front import tceu_pkg::*; #(
  parameter int REG_COUNT = 4
) (
  input  wire logic [INSTR_W-1:0] instruction,
  input  wire logic [INSTR_W-1:0] load_word,
  input  wire logic [ADDR_W-1:0]  rom_end,
  input  wire logic [ADDR_W-1:0]  ram_end,
  output dec_t                    dec
);

  localparam logic [REG_IDX_W:0] RC = (REG_IDX_W+1)'(REG_COUNT);

  logic [7:0]          opcode;
  logic [ADDR_W-1:0]   imm;
  logic [ADDR_W:0]     addr_top;
  logic                below_rom;
  logic                past_ram;
  logic [REG_IDX_W:0]  ra_w;
  logic [REG_IDX_W:0]  rb_w;

  assign opcode = instruction[31:24];
  assign imm    = instruction[15:0];

  // Reduce register fields modulo the register count by repeated subtract
  always_comb begin
    ra_w = {1'b0, instruction[23:20]};
    rb_w = {1'b0, instruction[19:16]};
    for (int k = 0; k < 8; k++) begin
      if (ra_w >= RC) ra_w = ra_w - RC;
      if (rb_w >= RC) rb_w = rb_w - RC;
    end
  end

  // Partition bounds: the last byte of the word must sit below ram_end
  assign addr_top  = {1'b0, imm} + (ADDR_W+1)'(3);
  assign below_rom = imm < rom_end;
  assign past_ram  = addr_top >= {1'b0, ram_end};

  // Classify and precompute the access error
  always_comb begin
    dec.ra  = ra_w[REG_IDX_W-1:0];
    dec.rb  = rb_w[REG_IDX_W-1:0];
    dec.imm = imm;
    dec.ld  = load_word[DATA_W-1:0];
    dec.err = ERR_NONE;
    case (opcode)
      OPC_MVR:   dec.cls = CL_MVR;
      OPC_MVI:   dec.cls = CL_MVI;
      OPC_ADDR:  dec.cls = CL_ADDR;
      OPC_ADDI:  dec.cls = CL_ADDI;
      OPC_SUBR:  dec.cls = CL_SUBR;
      OPC_SUBI:  dec.cls = CL_SUBI;
      OPC_CMP:   dec.cls = CL_CMP;
      OPC_JMP:   dec.cls = CL_JMP;
      OPC_JZ:    dec.cls = CL_JZ;
      OPC_JNZ:   dec.cls = CL_JNZ;
      OPC_HLT:   dec.cls = CL_HLT;
      OPC_NOP:   dec.cls = CL_NOP;
      OPC_LOAD: begin
        dec.cls = CL_LOAD;
        if (!below_rom && past_ram) dec.err = ERR_RANGE;
      end
      OPC_STORE: begin
        dec.cls = CL_STORE;
        if (below_rom)     dec.err = ERR_ROM;
        else if (past_ram) dec.err = ERR_RANGE;
      end
      default:   dec.cls = CL_BAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tceu_queue.sv =====
// Short FIFO of decoded words between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module tceu_queue import tceu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire dec_t push_word,
  output logic      pop_valid,
  input  wire logic pop,
  output dec_t      pop_word
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  dec_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = cnt_r != DEPTH_C;
  assign pop_valid  = cnt_r != '0;
  assign pop_word   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tceu_back.sv =====
// Back end: register file read stage, execute stage and output register.
`timescale 1ns / 1ps
`default_nettype none

module tceu_back import tceu_pkg::*; #(
  parameter int REG_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire dec_t              q_word,
  output logic                   q_pop,
  input  wire logic [ADDR_W-1:0] rom_end,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res_word
);

  localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // Register file storage with per-entry valid bits
  logic [DATA_W-1:0]    rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;

  // Operand stage
  logic              ex_v_r;
  dec_t              ex_d_r;
  logic [DATA_W-1:0] opa_r;
  logic [DATA_W-1:0] opb_r;

  // Architectural state and output register
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic              zf_r, zf_nxt;
  logic              halt_r, halt_nxt;
  logic              out_v_r;
  res_t              out_r, res_nxt;

  logic              fire;
  logic              wr;
  logic              st;
  logic              adv;
  logic [DATA_W-1:0] wval;
  logic [ERR_W-1:0]  err;
  logic [DATA_W-1:0] imm8;
  logic [RIW-1:0]    wa;
  logic [RIW-1:0]    qa;
  logic [RIW-1:0]    qb;

  assign fire  = ex_v_r && (!out_v_r || res_ready);
  assign q_pop = q_valid && (!ex_v_r || fire);
  assign imm8  = ex_d_r.imm[DATA_W-1:0];
  assign wa    = ex_d_r.ra[RIW-1:0];
  assign qa    = q_word.ra[RIW-1:0];
  assign qb    = q_word.rb[RIW-1:0];

  // Execute one decoded word against the current state
  always_comb begin
    wr       = 1'b0;
    st       = 1'b0;
    adv      = 1'b1;
    wval     = '0;
    err      = ERR_NONE;
    pc_nxt   = pc_r;
    zf_nxt   = zf_r;
    halt_nxt = halt_r;
    if (!halt_r) begin
      case (ex_d_r.cls)
        CL_MVR:  begin wval = opb_r;         wr = 1'b1; end
        CL_MVI:  begin wval = imm8;          wr = 1'b1; end
        CL_ADDR: begin wval = opa_r + opb_r; wr = 1'b1; end
        CL_ADDI: begin wval = opa_r + imm8;  wr = 1'b1; end
        CL_SUBR: begin wval = opa_r - opb_r; wr = 1'b1; end
        CL_SUBI: begin wval = opa_r - imm8;  wr = 1'b1; end
        CL_CMP:  zf_nxt = opa_r == opb_r;
        CL_JMP:  begin pc_nxt = ex_d_r.imm; adv = 1'b0; end
        CL_JZ: begin
          if (zf_r) begin pc_nxt = ex_d_r.imm; adv = 1'b0; end
        end
        CL_JNZ: begin
          if (!zf_r) begin pc_nxt = ex_d_r.imm; adv = 1'b0; end
        end
        CL_HLT:  begin halt_nxt = 1'b1; adv = 1'b0; end
        CL_NOP:  adv = 1'b1;
        CL_LOAD: begin
          err = ex_d_r.err;
          if (ex_d_r.err == ERR_NONE) begin wval = ex_d_r.ld; wr = 1'b1; end
        end
        CL_STORE: begin
          err = ex_d_r.err;
          st  = ex_d_r.err == ERR_NONE;
        end
        default: adv = 1'b0;
      endcase
      // An access error halts in place
      if (err != ERR_NONE) begin
        halt_nxt = 1'b1;
        adv      = 1'b0;
      end
      if (adv) pc_nxt = pc_r + ADDR_W'(1);
    end
  end

  // Assemble the result word
  always_comb begin
    res_nxt.next_pc          = pc_nxt;
    res_nxt.fetch_address    = rom_end + {pc_nxt[ADDR_W-3:0], 2'b00};
    res_nxt.zero_flag        = zf_nxt;
    res_nxt.halted           = halt_nxt;
    res_nxt.reg_write        = wr;
    res_nxt.written_register = wr ? ex_d_r.ra[1:0] : 2'b00;
    res_nxt.written_value    = wval;
    res_nxt.store_valid      = st;
    res_nxt.store_address    = st ? ex_d_r.imm : '0;
    res_nxt.store_data       = st ? opa_r : '0;
    res_nxt.error_code       = err;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pc_r     <= '0;
      zf_r     <= 1'b0;
      halt_r   <= 1'b0;
      rf_vld_r <= '0;
    end else begin
      ex_v_r <= q_pop || (ex_v_r && !fire);
      if (fire) begin
        out_v_r <= 1'b1;
        pc_r    <= pc_nxt;
        zf_r    <= zf_nxt;
        halt_r  <= halt_nxt;
        if (wr) rf_vld_r[wa] <= 1'b1;
      end else if (res_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Operand read with bypass of the write retiring at the same edge
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ex_d_r <= q_word;
      if (fire && wr && wa == qa) opa_r <= wval;
      else                        opa_r <= rf_vld_r[qa] ? rf_mem[qa] : '0;
      if (fire && wr && wa == qb) opb_r <= wval;
      else                        opb_r <= rf_vld_r[qb] ? rf_mem[qb] : '0;
    end
    if (fire) begin
      out_r <= res_nxt;
      if (wr) rf_mem[wa] <= wval;
    end
  end

  assign res_valid = out_v_r;
  assign res_word  = out_r;

endmodule

`default_nettype wire

// ===== rtl/tiny_cpu_execute_unit_top.sv =====
// Top level of the tiny CPU execute unit: config registers, front, queue, back.
//
//   channel | direction | handshake           | payload
//   in_ch   | sink      | valid / ready       | instruction, load_word
//   out_ch  | source    | valid / ready       | next_pc .. error_code (one per input)
//   cfg     | sink      | cfg_we, no ready    | cfg_index, cfg_wdata (rom_end, ram_end)
//
// One word per cycle sustained while out_ch.ready is high; an accepted word goes
// into a queue slot, then operand read, then execute into the output register.
// The operand read stage and the execute stage form the two-step register
// file loop; a write retiring in execute is bypassed into the read.
// Synchronous active-low reset clears control state; rom_end = 0, ram_end = 1024.
// The two-entry queue lets the front take words while the output stalls, until full.
`timescale 1ns / 1ps
`default_nettype none

module tiny_cpu_execute_unit_top import tceu_pkg::*; #(
  parameter int REG_COUNT = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  tceu_in_if.sink                   in_ch,
  tceu_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  logic [ADDR_W-1:0] rom_end_r;
  logic [ADDR_W-1:0] ram_end_r;
  dec_t              front_dec;
  dec_t              q_word;
  logic              q_valid;
  logic              q_pop;
  logic              res_valid;
  res_t              res_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_end_r <= ROM_END_RST;
      ram_end_r <= RAM_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_END: rom_end_r <= cfg_wdata;
        CFG_RAM_END: ram_end_r <= cfg_wdata;
        default:     rom_end_r <= rom_end_r;
      endcase
    end
  end

  tceu_front #(.REG_COUNT(REG_COUNT)) u_front (
    .instruction (in_ch.instruction),
    .load_word   (in_ch.load_word),
    .rom_end     (rom_end_r),
    .ram_end     (ram_end_r),
    .dec         (front_dec)
  );

  tceu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (in_ch.ready),
    .push_word  (front_dec),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_word   (q_word)
  );

  tceu_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .rom_end   (rom_end_r),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .res_word  (res_word)
  );

  // Drive the result channel
  assign out_ch.valid            = res_valid;
  assign out_ch.next_pc          = res_word.next_pc;
  assign out_ch.fetch_address    = res_word.fetch_address;
  assign out_ch.zero_flag        = res_word.zero_flag;
  assign out_ch.halted           = res_word.halted;
  assign out_ch.reg_write        = res_word.reg_write;
  assign out_ch.written_register = res_word.written_register;
  assign out_ch.written_value    = res_word.written_value;
  assign out_ch.store_valid      = res_word.store_valid;
  assign out_ch.store_address    = res_word.store_address;
  assign out_ch.store_data       = res_word.store_data;
  assign out_ch.error_code       = res_word.error_code;

endmodule

`default_nettype wire

// ===== rtl/tceu_checker.sv =====
// Port-level checker for the execute unit and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tceu_checker import tceu_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] out_next_pc,
  input wire logic              out_halted,
  input wire logic              out_reg_write,
  input wire logic              out_store_valid,
  input wire logic [ERR_W-1:0]  out_error_code
);

  logic seen_halt_r;

  // Remember that a halted word has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  // Stalled result word stays valid and keeps its next_pc
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc))
    else $error("result word changed while stalled");

  // An access error halts and suppresses all side effects
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |->
      out_halted && !out_reg_write && !out_store_valid)
    else $error("access error did not halt cleanly");

  // Once halted, the unit stays halted and does nothing
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |->
      out_halted && !out_reg_write && !out_store_valid && out_error_code == ERR_NONE)
    else $error("activity after halt");

  // A store never writes a register and never carries an error
  a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |-> !out_reg_write && out_error_code == ERR_NONE)
    else $error("store word with register write or error");

endmodule

bind tiny_cpu_execute_unit_top tceu_checker u_tceu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_next_pc     (out_ch.next_pc),
  .out_halted      (out_ch.halted),
  .out_reg_write   (out_ch.reg_write),
  .out_store_valid (out_ch.store_valid),
  .out_error_code  (out_ch.error_code)
);

`default_nettype wire
